// ===== src/aclp_pkg.sv =====
package aclp_pkg;

    localparam int VALUE_W = 32;

    localparam int NUM_CMD_WORDS = 10;
    localparam int NUM_TRG_WORDS = 5;
    localparam int NUM_DET_WORDS = 11;

    // Each keyword is three ASCII bytes, first byte in the top bits.
    localparam logic [23:0] CMD_WORDS [NUM_CMD_WORDS] = '{
        "REG", "PIN", "SET", "SAV", "DEF", "NFO", "VER", "RST", "LDE", "STE"
    };
    localparam logic [23:0] TRG_WORDS [NUM_TRG_WORDS] = '{
        "LMK", "LMX", "DAC", "LED", "VCO"
    };
    localparam logic [23:0] DET_WORDS [NUM_DET_WORDS] = '{
        "ENB", "GOE", "SYN", "OSC", "OUT", "PRT", "MIN", "MAX", "KBT", "DIV", "AUT"
    };

    typedef struct packed {
        logic [3:0] command_code;
        logic [2:0] target_code;
        logic [3:0] detail_code;
    } codes_t;

    typedef struct packed {
        logic [3:0]         command_code;
        logic [2:0]         target_code;
        logic [3:0]         detail_code;
        logic [VALUE_W-1:0] value;
        logic               ended_at_line_end;
    } record_t;

endpackage

// ===== src/aclp_kw_match.sv =====
module aclp_kw_match
(
    input  logic [23:0]    word,
    output aclp_pkg::codes_t codes
);

    always_comb
    begin
        codes = '0;
        // Scan downward so the lowest matching position wins.
        for (int i = aclp_pkg::NUM_CMD_WORDS - 1; i >= 0; i--)
        begin
            if (word == aclp_pkg::CMD_WORDS[i])
            begin
                codes.command_code = 4'(i + 1);
            end
        end
        for (int i = aclp_pkg::NUM_TRG_WORDS - 1; i >= 0; i--)
        begin
            if (word == aclp_pkg::TRG_WORDS[i])
            begin
                codes.target_code = 3'(i + 1);
            end
        end
        for (int i = aclp_pkg::NUM_DET_WORDS - 1; i >= 0; i--)
        begin
            if (word == aclp_pkg::DET_WORDS[i])
            begin
                codes.detail_code = 4'(i + 1);
            end
        end
    end

endmodule

// ===== src/aclp_parse_core.sv =====
module aclp_parse_core #(
    parameter int HEX_DIGITS = 8,
    parameter int DEC_DIGITS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    output logic              emit,
    output aclp_pkg::record_t rec
);

    localparam int MAX_DIGITS = (HEX_DIGITS > DEC_DIGITS) ? HEX_DIGITS : DEC_DIGITS;
    localparam int DIGIT_W    = $clog2(MAX_DIGITS + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic [1:0] LAST_FIELD = 2'd3;

    typedef enum logic [5:0] {
        PH_SKIP  = 6'b000001,
        PH_WORD2 = 6'b000010,
        PH_WORD3 = 6'b000100,
        PH_HEX   = 6'b001000,
        PH_DEC   = 6'b010000,
        PH_TAIL  = 6'b100000
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [1:0]                   field_index_reg, field_index_next;
    logic [7:0]                   first_char_reg, first_char_next;
    logic [7:0]                   second_char_reg, second_char_next;
    logic [3:0]                   command_reg, command_next;
    logic [2:0]                   target_reg, target_next;
    logic [3:0]                   detail_reg, detail_next;
    logic [aclp_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [DIGIT_W-1:0]           digit_count_reg, digit_count_next;

    aclp_pkg::codes_t codes;
    logic             line_end;
    logic             dec_ok;
    logic             hex_ok;
    logic [3:0]       dec_digit;
    logic [3:0]       hex_digit;
    logic [DIGIT_W-1:0] digit_count_inc;

    aclp_kw_match u_kw_match
    (
        .word  ({first_char_reg, second_char_reg, rx_byte}),
        .codes (codes)
    );

    always_comb
    begin
        line_end = (rx_byte == CH_NUL) || (rx_byte == CH_CR) || (rx_byte == CH_LF);

        dec_ok    = 1'b0;
        dec_digit = 4'd0;
        hex_ok    = 1'b0;
        hex_digit = 4'd0;
        case (rx_byte) inside
            ["0":"9"]:
            begin
                dec_ok    = 1'b1;
                dec_digit = 4'(rx_byte - "0");
                hex_ok    = 1'b1;
                hex_digit = 4'(rx_byte - "0");
            end
            ["a":"f"]:
            begin
                hex_ok    = 1'b1;
                hex_digit = 4'(rx_byte - "a" + 8'd10);
            end
            ["A":"F"]:
            begin
                hex_ok    = 1'b1;
                hex_digit = 4'(rx_byte - "A" + 8'd10);
            end
            default:
            begin
                hex_ok = 1'b0;
            end
        endcase
    end

    assign digit_count_inc = digit_count_reg + DIGIT_W'(1);

    always_comb
    begin
        phase_next        = phase_reg;
        field_index_next  = field_index_reg;
        first_char_next   = first_char_reg;
        second_char_next  = second_char_reg;
        command_next      = command_reg;
        target_next       = target_reg;
        detail_next       = detail_reg;
        value_next        = value_reg;
        digit_count_next  = digit_count_reg;
        emit              = 1'b0;
        rec.command_code      = command_reg;
        rec.target_code       = target_reg;
        rec.detail_code       = detail_reg;
        rec.value             = value_reg;
        rec.ended_at_line_end = 1'b0;

        case (phase_reg)
            PH_SKIP:
            begin
                if (rx_byte == CH_SPACE)
                begin
                    phase_next = PH_SKIP;
                end
                else if (rx_byte == CH_COMMA)
                begin
                    if (field_index_reg == LAST_FIELD)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        field_index_next = field_index_reg + 2'd1;
                    end
                end
                else if (line_end)
                begin
                    emit                  = 1'b1;
                    rec.ended_at_line_end = 1'b1;
                end
                else if (field_index_reg != LAST_FIELD)
                begin
                    first_char_next = rx_byte;
                    phase_next      = PH_WORD2;
                end
                else if ((rx_byte == CH_LOW_X) || (rx_byte == CH_UP_X))
                begin
                    digit_count_next = '0;
                    phase_next       = PH_HEX;
                end
                else if (dec_ok)
                begin
                    value_next       = aclp_pkg::VALUE_W'(dec_digit);
                    digit_count_next = DIGIT_W'(1);
                    phase_next       = (DEC_DIGITS <= 1) ? PH_TAIL : PH_DEC;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            PH_WORD2:
            begin
                second_char_next = rx_byte;
                phase_next       = PH_WORD3;
            end
            PH_WORD3:
            begin
                case (field_index_reg)
                    2'd0:    command_next = codes.command_code;
                    2'd1:    target_next  = codes.target_code;
                    default: detail_next  = codes.detail_code;
                endcase
                phase_next = PH_SKIP;
            end
            PH_HEX:
            begin
                if (!hex_ok)
                begin
                    emit                  = 1'b1;
                    rec.ended_at_line_end = line_end;
                end
                else
                begin
                    value_next       = {value_reg[aclp_pkg::VALUE_W-5:0], hex_digit};
                    digit_count_next = digit_count_inc;
                    if (digit_count_inc >= DIGIT_W'(HEX_DIGITS))
                    begin
                        phase_next = PH_TAIL;
                    end
                end
            end
            PH_DEC:
            begin
                if (!dec_ok)
                begin
                    emit                  = 1'b1;
                    rec.ended_at_line_end = line_end;
                end
                else
                begin
                    // Times ten as two shifted copies, wrapping at the word width.
                    value_next = (value_reg << 3) + (value_reg << 1)
                               + aclp_pkg::VALUE_W'(dec_digit);
                    digit_count_next = digit_count_inc;
                    if (digit_count_inc >= DIGIT_W'(DEC_DIGITS))
                    begin
                        phase_next = PH_TAIL;
                    end
                end
            end
            PH_TAIL:
            begin
                emit                  = 1'b1;
                rec.ended_at_line_end = line_end;
            end
            default:
            begin
                phase_next = PH_SKIP;
            end
        endcase

        // A finished record returns every field to its cleared value.
        if (emit)
        begin
            phase_next       = PH_SKIP;
            field_index_next = 2'd0;
            first_char_next  = 8'd0;
            second_char_next = 8'd0;
            command_next     = 4'd0;
            target_next      = 3'd0;
            detail_next      = 4'd0;
            value_next       = '0;
            digit_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SKIP;
            field_index_reg <= 2'd0;
            first_char_reg  <= 8'd0;
            second_char_reg <= 8'd0;
            command_reg     <= 4'd0;
            target_reg      <= 3'd0;
            detail_reg      <= 4'd0;
            value_reg       <= '0;
            digit_count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            field_index_reg <= field_index_next;
            first_char_reg  <= first_char_next;
            second_char_reg <= second_char_next;
            command_reg     <= command_next;
            target_reg      <= target_next;
            detail_reg      <= detail_next;
            value_reg       <= value_next;
            digit_count_reg <= digit_count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && emit) |=> (phase_reg == PH_SKIP) && (field_index_reg == 2'd0)
            && (value_reg == '0))
        else $error("parser state not cleared after a record");

    assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= DIGIT_W'(MAX_DIGITS))
        else $error("digit count beyond the longest number");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_WORD2) || (phase_reg == PH_WORD3)) |-> (field_index_reg != LAST_FIELD))
        else $error("keyword read in the number field");

endmodule

// ===== src/ascii_command_line_parser.sv =====
// Parses a received ASCII byte stream into command records, one byte per clock.
// Each accepted byte is held in an input register and processed once it can
// move on; a finished record is then loaded into an output register. The input
// stalls only while that output register holds a record that downstream has
// not taken yet, so with no output back-pressure the block sustains one byte
// every cycle.
module ascii_command_line_parser #(
    parameter int HEX_DIGITS = 8,
    parameter int DEC_DIGITS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  command_code,
    output logic [2:0]  target_code,
    output logic [3:0]  detail_code,
    output logic [31:0] value,
    output logic        ended_at_line_end
);

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    aclp_pkg::record_t out_rec_reg;

    logic              fire;
    logic              accept;
    logic              emit;
    aclp_pkg::record_t rec;

    aclp_parse_core #(
        .HEX_DIGITS (HEX_DIGITS),
        .DEC_DIGITS (DEC_DIGITS)
    ) u_parse_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (fire),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .rec     (rec)
    );

    // The held byte moves on whenever the result register is free or being emptied.
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= rx_byte;
        end
        if (fire && emit)
        begin
            out_rec_reg <= rec;
        end
    end

    assign out_valid         = out_valid_reg;
    assign command_code      = out_rec_reg.command_code;
    assign target_code       = out_rec_reg.target_code;
    assign detail_code       = out_rec_reg.detail_code;
    assign value             = out_rec_reg.value;
    assign ended_at_line_end = out_rec_reg.ended_at_line_end;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked record");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (command_code <= 4'd10) && (target_code <= 3'd5)
            && (detail_code <= 4'd11))
        else $error("keyword code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(out_rec_reg))
        else $error("stalled record changed");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    typedef aclp_pkg::record_t record_t;

    localparam int HEX_LEN     = 8;
    localparam int DEC_LEN     = 10;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [7:0] NUL_CH      = 8'h00;
    localparam logic [7:0] LF_CH       = 8'h0a;
    localparam logic [7:0] CR_CH       = 8'h0d;
    localparam logic [7:0] SPACE_CH    = " ";
    localparam logic [7:0] COMMA_CH    = ",";
    localparam logic [7:0] HEX_MARK_LO = "x";
    localparam logic [7:0] HEX_MARK_UP = "X";
    localparam logic [4:0] NOT_DIGIT   = 5'h10;

    localparam string CMD_LIST = "REGPINSETSAVDEFNFOVERRSTLDESTE";
    localparam string TRG_LIST = "LMKLMXDACLEDVCO";
    localparam string DET_LIST = "ENBGOESYNOSCOUTPRTMINMAXKBTDIVAUT";

    typedef enum logic [2:0] {P_SKIP, P_WORD2, P_WORD3, P_HEX, P_DEC, P_TAIL} parse_phase_t;

    typedef struct {
        string      text;
        logic [7:0] ending;
        bit         typed;
        record_t    rec;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  command_code;
    logic [2:0]  target_code;
    logic [3:0]  detail_code;
    logic [31:0] value;
    logic        ended_at_line_end;

    // Parser state as the block should hold it.
    parse_phase_t ps_phase;
    logic [2:0]   ps_field;
    logic [7:0]   ps_first;
    logic [7:0]   ps_second;
    logic [3:0]   ps_cmd;
    logic [2:0]   ps_trg;
    logic [3:0]   ps_det;
    logic [31:0]  ps_value;
    logic [3:0]   ps_digits;

    record_t pending_records [$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      long_hold_go = 1'b0;
    bit      long_hold_done = 1'b0;
    int      hold_left = 0;

    // Lines whose record is obvious are given their expected record; the rest
    // go through the predictor.
    stim_row_t dir_rows [17] = '{
        '{"", CR_CH, 1'b1, '{4'd0, 3'd0, 4'd0, 32'd0, 1'b1}},
        '{"", NUL_CH, 1'b1, '{4'd0, 3'd0, 4'd0, 32'd0, 1'b1}},
        '{"   ", LF_CH, 1'b1, '{4'd0, 3'd0, 4'd0, 32'd0, 1'b1}},
        '{",,,", COMMA_CH, 1'b1, '{4'd0, 3'd0, 4'd0, 32'd0, 1'b0}},
        '{"REG,LMK,ENB,xFFFFFFFF", CR_CH, 1'b1, '{4'd1, 3'd1, 4'd1, 32'hffffffff, 1'b1}},
        '{"STE,VCO,AUT,4294967295", COMMA_CH, 1'b1,
          '{4'd10, 3'd5, 4'd11, 32'hffffffff, 1'b0}},
        '{"reg,lmk,enb,X0", CR_CH, 1'b1, '{4'd0, 3'd0, 4'd0, 32'd0, 1'b1}},
        '{"RST,DAC,KBT,9999999999", LF_CH, 1'b0, '0},
        '{"  SAV , LMX , GOE ,  x1a2B", "g", 1'b0, '0},
        '{"S,\015", LF_CH, 1'b0, '0},
        '{"DEF,LED,DIV,", "q", 1'b0, '0},
        '{"PIN,,MIN,12", SPACE_CH, 1'b0, '0},
        '{"VER,,,x", NUL_CH, 1'b0, '0},
        '{"\377\200\177,,,0", CR_CH, 1'b0, '0},
        '{"NFO,LED,SYN,0000000000", "1", 1'b0, '0},
        '{"LDE,DAC,OSC,x12345678", "9", 1'b0, '0},
        '{"SET,LMX,PRT,77", CR_CH, 1'b0, '0}
    };

    ascii_command_line_parser #(
        .HEX_DIGITS(HEX_LEN),
        .DEC_DIGITS(DEC_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .command_code(command_code),
        .target_code(target_code),
        .detail_code(detail_code),
        .value(value),
        .ended_at_line_end(ended_at_line_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit is_line_end(input logic [7:0] b);
        return b == NUL_CH || b == CR_CH || b == LF_CH;
    endfunction

    function automatic logic [4:0] digit_value(input logic [7:0] b, input bit hex);
        if (b >= "0" && b <= "9")
            return 5'(b - "0");
        if (hex && b >= "a" && b <= "f")
            return 5'(b - "a" + 10);
        if (hex && b >= "A" && b <= "F")
            return 5'(b - "A" + 10);
        return NOT_DIGIT;
    endfunction

    function automatic logic [3:0] keyword_index(input string list, input logic [7:0] a,
                                                 input logic [7:0] b, input logic [7:0] c);
        for (int i = 0; i < list.len() / 3; i++)
        begin
            if (list[3*i] == a && list[3*i+1] == b && list[3*i+2] == c)
                return 4'(i + 1);
        end
        return 4'd0;
    endfunction

    function automatic void clear_parser();
        ps_phase  = P_SKIP;
        ps_field  = '0;
        ps_first  = '0;
        ps_second = '0;
        ps_cmd    = '0;
        ps_trg    = '0;
        ps_det    = '0;
        ps_value  = '0;
        ps_digits = '0;
    endfunction

    function automatic bit close_record(input bit at_line_end, output record_t rec);
        rec.command_code      = ps_cmd;
        rec.target_code       = ps_trg;
        rec.detail_code       = ps_det;
        rec.value             = ps_value;
        rec.ended_at_line_end = at_line_end;
        clear_parser();
        return 1'b1;
    endfunction

    // Advances the parser by one byte; returns 1 when the byte finishes a record.
    function automatic bit parse_byte(input logic [7:0] b, output record_t rec);
        logic [4:0] d;
        rec = '0;
        case (ps_phase)
            P_SKIP:
            begin
                if (b == SPACE_CH)
                    return 1'b0;
                if (b == COMMA_CH)
                begin
                    ps_field = ps_field + 3'd1;
                    if (ps_field >= 3'd4)
                        return close_record(1'b0, rec);
                    return 1'b0;
                end
                if (is_line_end(b))
                    return close_record(1'b1, rec);
                if (ps_field < 3'd3)
                begin
                    ps_first = b;
                    ps_phase = P_WORD2;
                    return 1'b0;
                end
                if (b == HEX_MARK_LO || b == HEX_MARK_UP)
                begin
                    ps_digits = '0;
                    ps_phase = P_HEX;
                    return 1'b0;
                end
                d = digit_value(b, 1'b0);
                if (d == NOT_DIGIT)
                    return close_record(1'b0, rec);
                ps_value  = 32'(d);
                ps_digits = 4'd1;
                ps_phase  = (DEC_LEN <= 1) ? P_TAIL : P_DEC;
            end
            P_WORD2:
            begin
                ps_second = b;
                ps_phase = P_WORD3;
            end
            P_WORD3:
            begin
                if (ps_field == 3'd0)
                    ps_cmd = keyword_index(CMD_LIST, ps_first, ps_second, b);
                else if (ps_field == 3'd1)
                    ps_trg = 3'(keyword_index(TRG_LIST, ps_first, ps_second, b));
                else
                    ps_det = keyword_index(DET_LIST, ps_first, ps_second, b);
                ps_phase = P_SKIP;
            end
            P_HEX:
            begin
                d = digit_value(b, 1'b1);
                if (d == NOT_DIGIT)
                    return close_record(is_line_end(b), rec);
                ps_value  = {ps_value[27:0], d[3:0]};
                ps_digits = ps_digits + 4'd1;
                if (ps_digits >= HEX_LEN)
                    ps_phase = P_TAIL;
            end
            P_DEC:
            begin
                d = digit_value(b, 1'b0);
                if (d == NOT_DIGIT)
                    return close_record(is_line_end(b), rec);
                ps_value  = ps_value * 32'd10 + 32'(d);
                ps_digits = ps_digits + 4'd1;
                if (ps_digits >= DEC_LEN)
                    ps_phase = P_TAIL;
            end
            default:
                return close_record(is_line_end(b), rec);
        endcase
        return 1'b0;
    endfunction

    function automatic logic [7:0] random_digit(input bit hex);
        int unsigned pick;
        pick = hex ? $urandom_range(2) : 0;
        case (pick)
            1: return 8'("a" + $urandom_range(5));
            2: return 8'("A" + $urandom_range(5));
            default: return 8'("0" + $urandom_range(9));
        endcase
    endfunction

    function automatic logic [7:0] random_line_end();
        case ($urandom_range(2))
            0: return NUL_CH;
            1: return CR_CH;
            default: return LF_CH;
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Offers one byte and waits for the transaction; the record that the byte
    // finishes, if any, joins the queue of pending records.
    task automatic send_byte(input logic [7:0] b, input bit use_typed, input record_t typed_rec);
        record_t predicted;
        bit      produced;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        produced = parse_byte(b, predicted);
        if (use_typed)
            pending_records.push_back(typed_rec);
        else if (produced)
            pending_records.push_back(predicted);
    endtask

    task automatic drain_records();
        in_valid <= 1'b0;
        while (pending_records.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Mostly well-formed command lines with random content, the rest noise
    // and runs of commas.
    task automatic send_random_lines(input int byte_budget);
        int         sent;
        int         mode;
        int         count;
        int         k;
        int         pick;
        string      list;
        bit         cut_short;
        logic [7:0] line_q [$];
        sent = 0;
        while (sent < byte_budget)
        begin
            line_q.delete();
            cut_short = 1'b0;
            mode = $urandom_range(99);
            if (mode < 75)
            begin
                for (int f = 0; f < 3 && !cut_short; f++)
                begin
                    count = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
                    repeat (count) line_q.push_back(SPACE_CH);
                    list = (f == 0) ? CMD_LIST : (f == 1) ? TRG_LIST : DET_LIST;
                    k = $urandom_range(list.len() / 3 - 1);
                    pick = $urandom_range(9);
                    if (pick < 7)
                    begin
                        for (int j = 0; j < 3; j++)
                            line_q.push_back(list[3*k+j]);
                    end
                    else if (pick == 7)
                    begin
                        // One letter in the wrong case must not match.
                        count = $urandom_range(2);
                        for (int j = 0; j < 3; j++)
                            line_q.push_back((j == count) ? list[3*k+j] ^ 8'h20 : list[3*k+j]);
                    end
                    else if (pick == 8)
                    begin
                        repeat (3) line_q.push_back(8'($urandom_range(255)));
                    end
                    if ($urandom_range(1) == 0)
                        line_q.push_back(SPACE_CH);
                    if ($urandom_range(24) == 0)
                    begin
                        line_q.push_back(random_line_end());
                        cut_short = 1'b1;
                    end
                    else
                        line_q.push_back(COMMA_CH);
                end
                if (!cut_short)
                begin
                    if ($urandom_range(3) == 0)
                        line_q.push_back(SPACE_CH);
                    pick = $urandom_range(9);
                    if (pick < 5)
                    begin
                        line_q.push_back(($urandom_range(1) == 0) ? HEX_MARK_LO : HEX_MARK_UP);
                        count = ($urandom_range(2) == 0) ? HEX_LEN : $urandom_range(HEX_LEN);
                        repeat (count) line_q.push_back(random_digit(1'b1));
                    end
                    else if (pick < 9)
                    begin
                        count = ($urandom_range(2) == 0) ? DEC_LEN : $urandom_range(1, DEC_LEN);
                        repeat (count) line_q.push_back(random_digit(1'b0));
                    end
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5: line_q.push_back(random_line_end());
                        6: line_q.push_back(COMMA_CH);
                        7: line_q.push_back(SPACE_CH);
                        8: line_q.push_back(8'($urandom_range(255)));
                        default: line_q.push_back(random_digit(1'b0));
                    endcase
                end
            end
            else if (mode < 90)
            begin
                count = $urandom_range(1, 8);
                repeat (count)
                begin
                    case ($urandom_range(5))
                        0: line_q.push_back(SPACE_CH);
                        1: line_q.push_back(COMMA_CH);
                        2: line_q.push_back(random_line_end());
                        3: line_q.push_back(HEX_MARK_UP);
                        4: line_q.push_back(random_digit(1'b1));
                        default: line_q.push_back(8'($urandom_range(255)));
                    endcase
                end
                if ($urandom_range(1) == 0)
                    line_q.push_back(random_line_end());
            end
            else
            begin
                count = $urandom_range(1, 5);
                repeat (count) line_q.push_back(COMMA_CH);
                if ($urandom_range(1) == 0)
                    line_q.push_back(random_line_end());
            end
            foreach (line_q[i])
                send_byte(line_q[i], 1'b0, '0);
            sent += line_q.size();
        end
    endtask

    // Output side: back-pressure and record checking.
    always @(posedge clk)
    begin
        record_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_records.size() == 0)
                begin
                    $error("record with nothing pending: cmd %0d trg %0d det %0d value 0x%0h",
                           command_code, target_code, detail_code, value);
                    error_count++;
                end
                else
                begin
                    want = pending_records.pop_front();
                    compare_field("command_code", 32'(want.command_code), 32'(command_code));
                    compare_field("target_code", 32'(want.target_code), 32'(target_code));
                    compare_field("detail_code", 32'(want.detail_code), 32'(detail_code));
                    compare_field("value", want.value, value);
                    compare_field("ended_at_line_end", 32'(want.ended_at_line_end),
                                  32'(ended_at_line_end));
                end
            end
            if (long_hold_go && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timed out after %0d cycles, %0d records pending",
                   cycle_count, pending_records.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        clear_parser();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 22;
        recv_idle_pct <= 86;
        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            for (int i = 0; i < row.text.len(); i++)
                send_byte(row.text[i], 1'b0, '0);
            send_byte(row.ending, row.typed, row.rec);
        end
        send_random_lines(50);
        drain_records();

        send_idle_pct = 86;
        recv_idle_pct <= 22;
        send_random_lines(50);
        drain_records();

        // No idling; one long output hold fills the block while bytes keep coming.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        long_hold_go <= 1'b1;
        send_random_lines(60);
        drain_records();

        repeat (20) @(posedge clk);
        if (pending_records.size() != 0)
        begin
            $error("%0d records never arrived", pending_records.size());
            error_count++;
        end
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
